>>> rtl/sorted_timer_queue_defines.svh
// Assertion macros for the sorted timer queue.
// No dependencies.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/stq_pkg.sv
// Types and constants for the sorted timer queue.
// No dependencies.
package stq_pkg;
   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_PROBE    = 3'd1;
   localparam logic [2:0] CMD_READ     = 3'd2;
   localparam logic [2:0] CMD_REARM_DF = 3'd3;
   localparam logic [2:0] CMD_REARM_DL = 3'd4;
   localparam logic [2:0] CMD_CLEAR    = 3'd5;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // ceil(2^31 / 10): exact floor divide by ten for 28-bit inputs, shift 31
   localparam logic [27:0] DIV10_MUL = 28'd214748365;

   typedef struct packed {
      logic [27:0] interval;
      logic [27:0] delay;
      logic [31:0] expiry;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now;
      logic [23:0] interval_ms;
      logic [23:0] delay_ms;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] remaining_ms;
      logic [31:0] head_payload;
      logic [27:0] head_interval;
      logic [27:0] head_delay;
      logic [31:0] head_expiry;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD_RD, S_HEAD_USE, S_DROP_RD, S_DROP_WR,
      S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
      S_DIV, S_RESP
   } state_type;

   // ms to ticks, masked to 28 bits
   function automatic logic [27:0] ms_to_ticks(input logic [23:0] ms);
      logic [27:0] w;
      begin
         w = {4'd0, ms};
         ms_to_ticks = (w << 3) + (w << 1);
      end
   endfunction
endpackage

>>> rtl/stq_if.sv
// Valid/ready channel carrying one word of a given type.
// Depends on nothing but the payload type passed in.
interface stq_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/stq_mem.sv
// Entry memory: one write port, one registered read port.
// Depends on stq_pkg.
module stq_mem #(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  stq_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output stq_pkg::entry_type  rd_data
);
   stq_pkg::entry_type mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/sorted_timer_queue.sv
// Sorted timer queue top level: sequencer around one entry memory.
// Probe divides by ten with a reciprocal multiply; add scans for its slot and
// shifts the entries above it up one; rearm shifts the rest down over the head,
// then reinserts it like an add. Each shift step reads an entry, then writes it.
// One command at a time: the next word waits until the response is accepted.
// Reset (synchronous, active high) empties the queue; memory contents stay.
`include "sorted_timer_queue_defines.svh"
module sorted_timer_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic clock,
   input logic reset,
   stq_if.sink   req,
   stq_if.source rsp
);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   stq_pkg::state_type state_ff, state_in;
   stq_pkg::req_type   cmd_ff, cmd_in;
   stq_pkg::rsp_type   out_ff, out_in;
   stq_pkg::entry_type new_ff, new_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               out_vld_ff, out_vld_in;
   logic [27:0]        rem_ff, rem_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   stq_pkg::entry_type wr_data, rd_data;

   stq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   assign req.ready = (state_ff == stq_pkg::S_IDLE) && !out_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= stq_pkg::S_IDLE;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
      end
      cmd_ff <= cmd_in; out_ff <= out_in; new_ff <= new_in;
      idx_ff <= idx_in; pos_ff <= pos_in; rem_ff <= rem_in;
   end

   logic [31:0] diff;
   logic [27:0] dly_t;
   logic [55:0] prod;
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; out_in = out_ff; new_in = new_ff;
      count_in = count_ff; idx_in = idx_ff; pos_in = pos_ff;
      out_vld_in = out_vld_ff; rem_in = rem_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = new_ff; rd_addr = '0;
      diff = rd_data.expiry - cmd_ff.now;
      dly_t = '0;
      prod = {28'd0, rem_ff} * {28'd0, stq_pkg::DIV10_MUL};
      if (out_vld_ff && rsp.ready) out_vld_in = 1'b0;
      case (state_ff)
         stq_pkg::S_IDLE: begin
            if (req.valid && !out_vld_ff) begin
               cmd_in = req.data;
               out_in = '0;
               state_in = stq_pkg::S_HEAD_RD;
            end
         end
         stq_pkg::S_HEAD_RD: begin
            rd_addr = '0;
            state_in = stq_pkg::S_HEAD_USE;
            case (cmd_ff.cmd)
               stq_pkg::CMD_ADD: begin
                  if (count_ff >= CW'(QUEUE_DEPTH)) begin
                     out_in.status = stq_pkg::ST_FULL;
                     state_in = stq_pkg::S_RESP;
                  end else begin
                     dly_t = stq_pkg::ms_to_ticks(cmd_ff.interval_ms);
                     new_in = '{dly_t, dly_t, {4'd0, dly_t} + cmd_ff.now,
                                cmd_ff.payload};
                     idx_in = '0; pos_in = count_ff;
                     state_in = stq_pkg::S_SCAN_RD;
                  end
               end
               stq_pkg::CMD_CLEAR: begin
                  count_in = '0;
                  state_in = stq_pkg::S_RESP;
               end
               stq_pkg::CMD_PROBE, stq_pkg::CMD_READ, stq_pkg::CMD_REARM_DF,
               stq_pkg::CMD_REARM_DL: begin
                  if (count_ff == '0) begin
                     out_in.status = stq_pkg::ST_EMPTY;
                     state_in = stq_pkg::S_RESP;
                  end
               end
               default: state_in = stq_pkg::S_RESP;
            endcase
         end
         stq_pkg::S_HEAD_USE: begin
            case (cmd_ff.cmd)
               stq_pkg::CMD_PROBE: begin
                  // an unexpired head has diff <= delay, so it fits 28 bits
                  rem_in = (diff > {4'd0, rd_data.delay}) ? 28'd0 : diff[27:0];
                  state_in = stq_pkg::S_DIV;
               end
               stq_pkg::CMD_READ: begin
                  out_in.head_payload  = rd_data.payload;
                  out_in.head_interval = rd_data.interval;
                  out_in.head_delay    = rd_data.delay;
                  out_in.head_expiry   = rd_data.expiry;
                  state_in = stq_pkg::S_RESP;
               end
               default: begin
                  // rearm: capture head, then shift the rest down
                  dly_t = (cmd_ff.cmd == stq_pkg::CMD_REARM_DF) ? rd_data.interval
                        : stq_pkg::ms_to_ticks(cmd_ff.delay_ms);
                  new_in = '{rd_data.interval, dly_t, cmd_ff.now + {4'd0, dly_t},
                             rd_data.payload};
                  idx_in = CW'(1);
                  state_in = stq_pkg::S_DROP_RD;
               end
            endcase
         end
         stq_pkg::S_DROP_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CW'(1);
               idx_in = '0; pos_in = count_ff - CW'(1);
               state_in = stq_pkg::S_SCAN_RD;
            end else begin
               rd_addr = idx_ff[AW-1:0];
               state_in = stq_pkg::S_DROP_WR;
            end
         end
         stq_pkg::S_DROP_WR: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(1)); wr_data = rd_data;
            idx_in = idx_ff + CW'(1);
            state_in = stq_pkg::S_DROP_RD;
         end
         stq_pkg::S_SCAN_RD: begin
            if (idx_ff >= count_ff) begin
               idx_in = count_ff;
               state_in = stq_pkg::S_SHIFT_RD;
            end else begin
               rd_addr = idx_ff[AW-1:0];
               state_in = stq_pkg::S_SCAN_CHK;
            end
         end
         stq_pkg::S_SCAN_CHK: begin
            if (diff <= {4'd0, rd_data.delay} && {4'd0, new_ff.delay} < diff) begin
               pos_in = idx_ff; idx_in = count_ff;
               state_in = stq_pkg::S_SHIFT_RD;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = stq_pkg::S_SCAN_RD;
            end
         end
         stq_pkg::S_SHIFT_RD: begin
            // move entries pos..count-1 up one, top first
            if (idx_ff <= pos_ff) begin
               state_in = stq_pkg::S_PLACE;
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = stq_pkg::S_SHIFT_WR;
            end
         end
         stq_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
            idx_in = idx_ff - CW'(1);
            state_in = stq_pkg::S_SHIFT_RD;
         end
         stq_pkg::S_PLACE: begin
            wr_en = 1'b1; wr_addr = pos_ff[AW-1:0]; wr_data = new_ff;
            count_in = count_ff + CW'(1);
            state_in = stq_pkg::S_RESP;
         end
         stq_pkg::S_DIV: begin
            // divide by ten: reciprocal multiply, keep bits above 2^31
            out_in.remaining_ms = prod[54:31];
            state_in = stq_pkg::S_RESP;
         end
         stq_pkg::S_RESP: begin
            if (!out_vld_ff) begin
               out_in.entry_count = 5'(count_ff);
               out_vld_in = 1'b1;
               state_in = stq_pkg::S_IDLE;
            end
         end
         default: state_in = stq_pkg::S_IDLE;
      endcase
   end

   `STQ_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `STQ_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == stq_pkg::S_IDLE)
   `STQ_ASSERT_NXT(a_place_inc, clock, reset, state_ff == stq_pkg::S_PLACE,
      count_ff == $past(count_ff) + CW'(1))
   `STQ_ASSERT_IMP(a_wr_inrange, clock, reset, wr_en,
      wr_addr < AW'(QUEUE_DEPTH - 1) || wr_addr == AW'(QUEUE_DEPTH - 1))
endmodule

>>> tb/tb_sorted_timer_queue.sv
// Testbench for the sorted timer queue: directed and random commands with a
// built-in predictor of the ordered entry list. Depends on stq_pkg and stq_if.
module tb_sorted_timer_queue;
   localparam int DEPTH = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   int   error_count;
   int   idle_cycles;

   stq_if #(.word_type(stq_pkg::req_type)) req_ch ();
   stq_if #(.word_type(stq_pkg::rsp_type)) rsp_ch ();

   sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   // predicted queue contents
   stq_pkg::entry_type timers[$];
   stq_pkg::rsp_type   pending_rsp[$];
   logic [31:0] clock_now;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [27:0] to_ticks(input logic [23:0] ms);
      logic [27:0] t;
      t = 28'(ms) * 28'd10;
      return t;
   endfunction

   // insert before first unexpired entry with larger remaining time
   function automatic void insert_timer(input stq_pkg::entry_type e,
                                        input logic [31:0] now);
      int pos;
      logic [31:0] rem;
      pos = timers.size();
      for (int k = 0; k < timers.size(); k++) begin
         rem = timers[k].expiry - now;
         if (rem <= 32'(timers[k].delay) && 32'(e.delay) < rem) begin
            pos = k;
            break;
         end
      end
      timers.insert(pos, e);
   endfunction

   function automatic stq_pkg::rsp_type predict_timer(input stq_pkg::req_type r);
      stq_pkg::rsp_type o;
      stq_pkg::entry_type e;
      logic [31:0] rem;
      o = '0;
      case (r.cmd)
         stq_pkg::CMD_ADD: begin
            if (timers.size() >= DEPTH) begin
               o.status = stq_pkg::ST_FULL;
            end else begin
               e.interval = to_ticks(r.interval_ms);
               e.delay = e.interval;
               e.expiry = 32'(e.interval) + r.now;
               e.payload = r.payload;
               insert_timer(e, r.now);
            end
         end
         stq_pkg::CMD_PROBE: begin
            if (timers.size() == 0) begin
               o.status = stq_pkg::ST_EMPTY;
            end else begin
               rem = timers[0].expiry - r.now;
               o.remaining_ms = (rem > 32'(timers[0].delay)) ? 24'd0 : 24'(rem / 10);
            end
         end
         stq_pkg::CMD_READ: begin
            if (timers.size() == 0) begin
               o.status = stq_pkg::ST_EMPTY;
            end else begin
               o.head_payload = timers[0].payload;
               o.head_interval = timers[0].interval;
               o.head_delay = timers[0].delay;
               o.head_expiry = timers[0].expiry;
            end
         end
         stq_pkg::CMD_REARM_DF, stq_pkg::CMD_REARM_DL: begin
            if (timers.size() == 0) begin
               o.status = stq_pkg::ST_EMPTY;
            end else begin
               e = timers.pop_front();
               e.delay = (r.cmd == stq_pkg::CMD_REARM_DF) ? e.interval
                                                           : to_ticks(r.delay_ms);
               e.expiry = r.now + 32'(e.delay);
               insert_timer(e, r.now);
            end
         end
         stq_pkg::CMD_CLEAR: timers.delete();
         default: ;
      endcase
      o.entry_count = 5'(timers.size());
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // send one command word and record its expected response
   task automatic send_word(input stq_pkg::req_type r);
      int gap;
      gap = pick_gap();
      // valid drops only across a gap; back to back words keep it high
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.data <= r;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(predict_timer(r));
      @(negedge clock);
   endtask

   task automatic send_cmd(input logic [2:0] c, input logic [23:0] ivl,
                           input logic [23:0] dly, input logic [31:0] pay);
      stq_pkg::req_type r;
      r.cmd = c;
      r.now = clock_now;
      r.interval_ms = ivl;
      r.delay_ms = dly;
      r.payload = pay;
      send_word(r);
   endtask

   task automatic drain_pending();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   // empty-queue cases, unused codes and extreme fields
   task automatic test_directed();
      send_cmd(stq_pkg::CMD_PROBE, 0, 0, 0);
      send_cmd(stq_pkg::CMD_READ, 0, 0, 0);
      send_cmd(stq_pkg::CMD_REARM_DF, 0, 0, 0);
      send_cmd(stq_pkg::CMD_REARM_DL, 0, 24'hFFFFFF, 0);
      send_cmd(3'd6, 24'hFFFFFF, 24'hFFFFFF, '1);
      send_cmd(3'd7, 0, 0, 0);
      clock_now = 32'hFFFF_FFF0;
      send_cmd(stq_pkg::CMD_ADD, 24'hFFFFFF, 0, 32'hFFFF_FFFF);
      send_cmd(stq_pkg::CMD_ADD, 0, 0, 32'h0);
      send_cmd(stq_pkg::CMD_ADD, 5, 0, 32'h1234_5678);
      send_cmd(stq_pkg::CMD_READ, 0, 0, 0);
      send_cmd(stq_pkg::CMD_PROBE, 0, 0, 0);
      clock_now = clock_now + 32'd200;
      send_cmd(stq_pkg::CMD_PROBE, 0, 0, 0);
      send_cmd(stq_pkg::CMD_REARM_DF, 0, 0, 0);
      send_cmd(stq_pkg::CMD_REARM_DL, 0, 24'hFFFFFF, 0);
      send_cmd(stq_pkg::CMD_READ, 0, 0, 0);
      send_cmd(stq_pkg::CMD_CLEAR, 0, 0, 0);
   endtask

   // fill past the limit to hit the full status
   task automatic test_full_queue();
      for (int i = 0; i < DEPTH + 2; i++)
         send_cmd(stq_pkg::CMD_ADD, 24'($urandom_range(0, 50)), 0, $urandom);
      send_cmd(stq_pkg::CMD_READ, 0, 0, 0);
      drain_pending();
      send_cmd(stq_pkg::CMD_CLEAR, 0, 0, 0);
   endtask

   // random commands: mostly adds and rearms over a moving clock
   task automatic test_random(input int n);
      logic [2:0]  c;
      logic [23:0] ivl;
      logic [23:0] dly;
      int p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 35) c = stq_pkg::CMD_ADD;
         else if (p < 50) c = stq_pkg::CMD_PROBE;
         else if (p < 62) c = stq_pkg::CMD_READ;
         else if (p < 75) c = stq_pkg::CMD_REARM_DF;
         else if (p < 90) c = stq_pkg::CMD_REARM_DL;
         else if (p < 94) c = stq_pkg::CMD_CLEAR;
         else c = 3'($urandom_range(6, 7));
         ivl = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
         dly = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
         clock_now = clock_now + (($urandom_range(0, 19) == 0) ? $urandom
                                                              : $urandom_range(0, 1500));
         send_cmd(c, ivl, dly, $urandom);
         if (i == n / 2) drain_pending();
      end
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      stq_pkg::rsp_type want;
      stq_pkg::rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response word");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); error_count++;
            end
            if (got.remaining_ms !== want.remaining_ms) begin
               $error("remaining_ms exp %0d got %0d", want.remaining_ms, got.remaining_ms);
               error_count++;
            end
            if (got.head_payload !== want.head_payload) begin
               $error("head_payload exp %0h got %0h", want.head_payload, got.head_payload);
               error_count++;
            end
            if (got.head_interval !== want.head_interval) begin
               $error("head_interval exp %0d got %0d", want.head_interval, got.head_interval);
               error_count++;
            end
            if (got.head_delay !== want.head_delay) begin
               $error("head_delay exp %0d got %0d", want.head_delay, got.head_delay);
               error_count++;
            end
            if (got.head_expiry !== want.head_expiry) begin
               $error("head_expiry exp %0h got %0h", want.head_expiry, got.head_expiry);
               error_count++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count exp %0d got %0d", want.entry_count, got.entry_count);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      clock_now = 32'd0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_queue();
      test_random(1010);
      drain_pending();
      repeat (200) @(negedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
